// ===== design/gfq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gfq_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int GROUPS_DEF   = 16;
	localparam int TAG_BITS_DEF = 16;

	// field widths of the channel payloads
	localparam int GROUP_W     = 4;
	localparam int TAG_W       = 16;
	localparam int STATUS_W    = 2;
	localparam int GROUP_CODES = 2 ** GROUP_W;

	localparam logic [STATUS_W-1:0] RSP_ENQUEUED = 2'd0;
	localparam logic [STATUS_W-1:0] RSP_DEQUEUED = 2'd1;
	localparam logic [STATUS_W-1:0] RSP_EMPTY    = 2'd2;
	localparam logic [STATUS_W-1:0] RSP_FULL     = 2'd3;

	localparam logic REQ_ENQ = 1'b0;
	localparam logic REQ_DEQ = 1'b1;

	typedef struct packed {
		logic               req_type;
		logic [GROUP_W-1:0] group_id;
		logic [TAG_W-1:0]   tag_in;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [GROUP_W-1:0]  group_out;
		logic [TAG_W-1:0]    tag_out;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic enq_rd;
		logic enq_wr;
		logic enq_link;
		logic deq_rd;
		logic deq_wr;
		logic load_out;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_deq;
		logic full;
		logic empty;
	} sts_t;

endpackage

`default_nettype wire

// ===== design/gfq_chan_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface gfq_chan_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== design/grouped_fifo_queue_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Team queue: an enqueue links its entry directly behind the last waiting
// member of its group, or at the global tail when none of that group waits;
// a dequeue returns the head entry. Each request gives exactly one result:
// status enqueued, dequeued, empty or full. One request is in work at a
// time, and the next is taken while the previous result still waits in the
// output register. An enqueue steps through read, write and link, a
// dequeue through read and write, a rejected (full or empty) request
// straight to finish, where the result waits for the output register to
// free up. The steps come from the chain of registered reads through the
// free stack, the group table and the single-port link memory, and the
// link memory taking one write a cycle (new entry, then predecessor's link).
// No clearing pass is needed after reset: the free stack is tracked by a high-water mark.
module grouped_fifo_queue_unit #(
	parameter int CAPACITY = gfq_pkg::CAPACITY_DEF,
	parameter int GROUPS   = gfq_pkg::GROUPS_DEF,
	parameter int TAG_BITS = gfq_pkg::TAG_BITS_DEF
) (
	input wire logic   clk,
	input wire logic   arst_n,
	gfq_chan_if.sink   req,
	gfq_chan_if.source rsp
);
	import gfq_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic in_ready;
	logic out_valid;
	rsp_t rsp_payload;

	gfq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	gfq_datapath #(
		.CAPACITY (CAPACITY),
		.GROUPS   (GROUPS),
		.TAG_BITS (TAG_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_payload (req.payload),
		.cmd         (cmd),
		.sts         (sts),
		.rsp_payload (rsp_payload)
	);

	assign req.ready   = in_ready;
	assign rsp.valid   = out_valid;
	assign rsp.payload = rsp_payload;

endmodule

`default_nettype wire

// ===== design/gfq_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gfq_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          rsp_ready,
	input  wire gfq_pkg::sts_t sts,
	output gfq_pkg::cmd_t      cmd
);
	import gfq_pkg::*;

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_ENQ_RD   = 3'd1;
	localparam logic [2:0] S_ENQ_WR   = 3'd2;
	localparam logic [2:0] S_ENQ_LINK = 3'd3;
	localparam logic [2:0] S_DEQ_RD   = 3'd4;
	localparam logic [2:0] S_DEQ_WR   = 3'd5;
	localparam logic [2:0] S_FIN      = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;

	always_comb begin
		cmd          = '0;
		state_d      = state_q;
		cmd.accept   = (state_q == S_IDLE) && in_valid;
		cmd.load_out = (state_q == S_FIN) && (!out_valid_q || rsp_ready);
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (sts.is_deq) begin
						state_d = sts.empty ? S_FIN : S_DEQ_RD;
					end else begin
						state_d = sts.full ? S_FIN : S_ENQ_RD;
					end
				end
			end
			S_ENQ_RD: begin
				cmd.enq_rd = 1'b1;
				state_d    = S_ENQ_WR;
			end
			S_ENQ_WR: begin
				cmd.enq_wr = 1'b1;
				state_d    = S_ENQ_LINK;
			end
			S_ENQ_LINK: begin
				cmd.enq_link = 1'b1;
				state_d      = S_FIN;
			end
			S_DEQ_RD: begin
				cmd.deq_rd = 1'b1;
				state_d    = S_DEQ_WR;
			end
			S_DEQ_WR: begin
				cmd.deq_wr = 1'b1;
				state_d    = S_FIN;
			end
			S_FIN: begin
				if (cmd.load_out) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// a result waits for the output slot as long as the slot stays blocked
	a_fin_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && out_valid_q && !rsp_ready) |=> state_q == S_FIN)
		else $error("result left the finish state while the output was blocked");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid_q)
		else $error("loaded result not presented");

endmodule

`default_nettype wire

// ===== design/gfq_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gfq_datapath #(
	parameter int CAPACITY = gfq_pkg::CAPACITY_DEF,
	parameter int GROUPS   = gfq_pkg::GROUPS_DEF,
	parameter int TAG_BITS = gfq_pkg::TAG_BITS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire gfq_pkg::req_t req_payload,
	input  wire gfq_pkg::cmd_t cmd,
	output gfq_pkg::sts_t      sts,
	output gfq_pkg::rsp_t      rsp_payload
);
	import gfq_pkg::*;

	localparam int SW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int GW = $clog2(GROUPS);

	// link store and free stack
	logic [GROUP_W-1:0]  grp_mem  [CAPACITY];
	logic [TAG_BITS-1:0] tag_mem  [CAPACITY];
	logic [SW-1:0]       next_mem [CAPACITY];
	logic [SW-1:0]       free_mem [CAPACITY];
	logic [SW-1:0]       glast_mem [GROUPS];

	logic [GROUP_W-1:0]  gmod [GROUP_CODES];

	logic [CW-1:0]       occ_q;
	logic [CW-1:0]       hwm_q;
	logic [SW-1:0]       head_q;
	logic [SW-1:0]       tail_q;
	logic [GROUPS-1:0]   wait_q;

	logic [GROUP_W-1:0]  g_q;
	logic [GW-1:0]       gidx_q;
	logic [TAG_BITS-1:0] t_q;
	logic                fresh_q;
	logic [SW-1:0]       slot_q;
	logic                link_en_q;
	logic [SW-1:0]       link_addr_q;
	logic [STATUS_W-1:0] res_status_q;
	rsp_t                out_q;

	logic [GROUP_W-1:0]  grp_rd_q;
	logic [TAG_BITS-1:0] tag_rd_q;
	logic [SW-1:0]       next_rd_q;
	logic [SW-1:0]       free_rd_q;
	logic [SW-1:0]       glast_rd_q;

	logic [GROUP_W-1:0]  g_in;
	logic [GW-1:0]       gidx_in;
	logic [GW-1:0]       hidx;
	logic                wait_g;
	logic [CW-1:0]       occ_dec;
	logic                is_full;
	logic                is_empty;

	// group number reduced modulo the group count, one entry per input code
	for (genvar i = 0; i < GROUP_CODES; i++) begin : g_mod
		assign gmod[i] = GROUP_W'(i % GROUPS);
	end

	assign g_in     = gmod[req_payload.group_id];
	assign gidx_in  = GW'(g_in);
	assign hidx     = GW'(grp_rd_q);
	assign wait_g   = wait_q[gidx_q];
	assign occ_dec  = occ_q - CW'(1);
	assign is_full  = (occ_q == CW'(CAPACITY));
	assign is_empty = (occ_q == '0);

	assign sts.is_deq = req_payload.req_type;
	assign sts.full   = is_full;
	assign sts.empty  = is_empty;

	// memories and their registered reads
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			grp_rd_q  <= grp_mem[head_q];
			tag_rd_q  <= tag_mem[head_q];
			next_rd_q <= next_mem[head_q];
			free_rd_q <= free_mem[occ_q[SW-1:0]];
			glast_rd_q <= glast_mem[gidx_in];
		end else if (cmd.enq_rd) begin
			next_rd_q <= next_mem[glast_rd_q];
		end else if (cmd.deq_rd) begin
			glast_rd_q <= glast_mem[hidx];
		end

		if (cmd.enq_wr) begin
			grp_mem[slot_q]   <= g_q;
			tag_mem[slot_q]   <= t_q;
			next_mem[slot_q]  <= (!is_empty && wait_g) ? next_rd_q : '0;
			glast_mem[gidx_q] <= slot_q;
		end else if (cmd.enq_link && link_en_q) begin
			next_mem[link_addr_q] <= slot_q;
		end

		if (cmd.deq_wr) begin
			free_mem[occ_dec[SW-1:0]] <= head_q;
		end
	end

	// request capture and link bookkeeping
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			g_q     <= g_in;
			gidx_q  <= gidx_in;
			t_q     <= TAG_BITS'(req_payload.tag_in);
			fresh_q <= (occ_q == hwm_q);
			if (req_payload.req_type == REQ_DEQ) begin
				res_status_q <= is_empty ? RSP_EMPTY : RSP_DEQUEUED;
			end else begin
				res_status_q <= is_full ? RSP_FULL : RSP_ENQUEUED;
			end
		end
		if (cmd.enq_rd) begin
			// slots at or above the high-water mark were never pushed back
			slot_q <= fresh_q ? occ_q[SW-1:0] : free_rd_q;
		end
		if (cmd.enq_wr) begin
			link_en_q   <= !is_empty;
			link_addr_q <= wait_g ? glast_rd_q : tail_q;
		end
		if (cmd.load_out) begin
			out_q.status    <= res_status_q;
			out_q.group_out <= (res_status_q == RSP_DEQUEUED) ? grp_rd_q : '0;
			out_q.tag_out   <= (res_status_q == RSP_DEQUEUED) ? TAG_W'(tag_rd_q) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q  <= '0;
			hwm_q  <= '0;
			head_q <= '0;
			tail_q <= '0;
			wait_q <= '0;
		end else begin
			if (cmd.enq_wr) begin
				occ_q          <= occ_q + CW'(1);
				wait_q[gidx_q] <= 1'b1;
				if (fresh_q) begin
					hwm_q <= hwm_q + CW'(1);
				end
				if (is_empty) begin
					head_q <= slot_q;
					tail_q <= slot_q;
				end else if (!wait_g || glast_rd_q == tail_q) begin
					tail_q <= slot_q;
				end
			end else if (cmd.deq_wr) begin
				occ_q  <= occ_dec;
				head_q <= next_rd_q;
				if (wait_q[hidx] && glast_rd_q == head_q) begin
					wait_q[hidx] <= 1'b0;
				end
			end
		end
	end

	assign rsp_payload = out_q;

	a_hwm: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= hwm_q && hwm_q <= CW'(CAPACITY))
		else $error("occupancy above high-water mark");

	a_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(occ_q == '0) |-> (wait_q == '0))
		else $error("group marked waiting in an empty queue");

	a_enq_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.enq_wr |=> occ_q == $past(occ_q) + CW'(1))
		else $error("enqueue did not bump occupancy");

	a_deq_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.deq_wr |-> occ_q != '0)
		else $error("dequeue write on an empty queue");

endmodule

`default_nettype wire

// ===== dv/tb_grouped_fifo_queue_unit.sv =====
`timescale 1ns / 1ps

module tb_grouped_fifo_queue_unit;
	import gfq_pkg::*;

	localparam int CAP = CAPACITY_DEF;
	localparam int GRP = GROUPS_DEF;
	localparam int LONG_HOLD_CYCLES = 300;

	logic clk;
	logic arst_n = 1'b0;

	gfq_chan_if #(.payload_t(req_t)) req_if ();
	gfq_chan_if #(.payload_t(rsp_t)) rsp_if ();

	grouped_fifo_queue_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if.sink),
		.rsp    (rsp_if.source)
	);

	// requests waiting to be offered, and results owed by the block
	req_t pending_requests[$];
	rsp_t owed_results[$];
	int   errors = 0;

	int send_idle_pct = 0;
	int rcv_stall_pct = 0;
	int long_holds_asked = 0;
	int long_holds_done;
	int hold_left;

	// shadow of the team queue
	logic [GROUP_W-1:0] slot_group[CAP];
	logic [TAG_W-1:0]   slot_tag[CAP];
	logic [5:0]         slot_link[CAP];
	logic [5:0]         free_stack[CAP];
	int                 fill;
	logic [5:0]         first_slot;
	logic [5:0]         last_slot;
	logic [5:0]         grp_last[GRP];
	bit                 grp_live[GRP];

	function automatic rsp_t team_queue_predict(req_t r);
		rsp_t       o;
		logic [5:0] s;
		logic [5:0] p;
		logic [5:0] h;
		int         g;
		o = '0;
		o.status = RSP_EMPTY;
		if (r.req_type == REQ_ENQ) begin
			g = int'(r.group_id) % GRP;
			if (fill >= CAP) begin
				o.status = RSP_FULL;
			end else begin
				s = free_stack[CAP - fill - 1];
				slot_group[s] = GROUP_W'(g);
				slot_tag[s] = r.tag_in;
				slot_link[s] = '0;
				if (fill == 0) begin
					first_slot = s;
					last_slot = s;
				end else if (grp_live[g]) begin
					// splice in behind the group's last waiting member
					p = grp_last[g];
					slot_link[s] = slot_link[p];
					slot_link[p] = s;
					if (p == last_slot)
						last_slot = s;
				end else begin
					slot_link[last_slot] = s;
					last_slot = s;
				end
				grp_last[g] = s;
				grp_live[g] = 1'b1;
				fill++;
				o.status = RSP_ENQUEUED;
			end
		end else if (fill != 0) begin
			h = first_slot;
			g = int'(slot_group[h]) % GRP;
			o.group_out = slot_group[h];
			o.tag_out = slot_tag[h];
			if (grp_live[g] && grp_last[g] == h)
				grp_live[g] = 1'b0;
			first_slot = slot_link[h];
			free_stack[CAP - fill] = h;
			fill--;
			o.status = RSP_DEQUEUED;
		end
		return o;
	endfunction

	task automatic add_request(logic kind, logic [GROUP_W-1:0] g, logic [TAG_W-1:0] t);
		req_t r;
		r.req_type = kind;
		r.group_id = g;
		r.tag_in = t;
		pending_requests = {pending_requests, r};
	endtask

	// random requests; a few groups get most entries so that chains grow deep
	task automatic add_random_run(int count, int enq_pct);
		logic [GROUP_W-1:0] g;
		for (int i = 0; i < count; i++) begin
			g = $urandom_range(1) ? GROUP_W'($urandom_range(3)) : GROUP_W'($urandom_range(15));
			add_request(($urandom_range(99) < enq_pct) ? REQ_ENQ : REQ_DEQ, g,
				TAG_W'($urandom));
		end
	endtask

	task automatic wait_all_done();
		while (pending_requests.size() != 0 || req_if.valid || owed_results.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_if.valid <= 1'b0;
			req_if.payload <= '0;
		end else begin
			if (req_if.valid && req_if.ready)
				owed_results = {owed_results, team_queue_predict(req_if.payload)};
			if (!req_if.valid || req_if.ready) begin
				if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					req_if.payload <= pending_requests.pop_front();
					req_if.valid <= 1'b1;
				end else begin
					req_if.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver backpressure
	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
			long_holds_done <= 0;
			hold_left <= 0;
		end else begin
			if (rsp_if.valid && rsp_if.ready) begin
				if (owed_results.size() == 0) begin
					$display("%0t: result with nothing owed: status %0d group %0d tag %h",
						$time, rsp_if.payload.status, rsp_if.payload.group_out,
						rsp_if.payload.tag_out);
					errors++;
				end else begin
					want = owed_results.pop_front();
					if (rsp_if.payload.status !== want.status
							|| rsp_if.payload.group_out !== want.group_out
							|| rsp_if.payload.tag_out !== want.tag_out) begin
						$display("%0t: mismatch: expected status %0d group %0d tag %h",
							$time, want.status, want.group_out, want.tag_out,
							", got status %0d group %0d tag %h",
							rsp_if.payload.status, rsp_if.payload.group_out,
							rsp_if.payload.tag_out);
						errors++;
					end
				end
			end
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				rsp_if.ready <= 1'b0;
			end else if (long_holds_done != long_holds_asked) begin
				long_holds_done <= long_holds_done + 1;
				hold_left <= LONG_HOLD_CYCLES;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= ($urandom_range(99) >= rcv_stall_pct);
			end
		end
	end

	initial begin
		req_if.valid = 1'b0;
		req_if.payload = '0;
		rsp_if.ready = 1'b0;
		for (int i = 0; i < CAP; i++) begin
			slot_group[i] = '0;
			slot_tag[i] = '0;
			slot_link[i] = '0;
			free_stack[i] = 6'(CAP - 1 - i);
		end
		for (int i = 0; i < GRP; i++) begin
			grp_last[i] = '0;
			grp_live[i] = 1'b0;
		end
		fill = 0;
		first_slot = '0;
		last_slot = '0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// dequeue on empty, field extremes, splicing, group at tail, drains
		add_request(REQ_DEQ, 4'd0, 16'h0000);
		add_request(REQ_ENQ, 4'd0, 16'h0000);
		add_request(REQ_ENQ, 4'd15, 16'hffff);
		add_request(REQ_ENQ, 4'd0, 16'h1234);
		add_request(REQ_ENQ, 4'd15, 16'haaaa);
		add_request(REQ_ENQ, 4'd7, 16'h5555);
		add_request(REQ_ENQ, 4'd0, 16'h8001);
		repeat (6) add_request(REQ_DEQ, 4'd15, 16'hffff);
		add_request(REQ_DEQ, 4'd9, 16'h0f0f);
		add_request(REQ_ENQ, 4'd3, 16'h8001);
		add_request(REQ_DEQ, 4'd0, 16'h0000);
		add_request(REQ_ENQ, 4'd3, 16'h7ffe);
		add_request(REQ_ENQ, 4'd3, 16'h0001);
		add_request(REQ_DEQ, 4'd0, 16'h0000);
		add_request(REQ_DEQ, 4'd0, 16'h0000);
		add_request(REQ_DEQ, 4'd0, 16'h0000);
		wait_all_done();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  rcv_stall_pct = 0;  end
				1: begin send_idle_pct = 48; rcv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  rcv_stall_pct = 48; end
				default: begin send_idle_pct = 22; rcv_stall_pct = 22; end
			endcase
			// long receiver hold-off while the fill run is offered
			if (ph == 0 || ph == 3)
				long_holds_asked++;
			add_random_run(100, 90);
			add_random_run(25, 50);
			add_random_run(100, 10);
			// sender pauses until everything owed has arrived
			wait_all_done();
		end

		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("tb_grouped_fifo_queue_unit: clean");
		else
			$display("tb_grouped_fifo_queue_unit: errors");
		$finish;
	end

	initial begin
		#4000000;
		$display("tb_grouped_fifo_queue_unit: errors");
		$finish;
	end

endmodule

// ===== files.f =====
design/gfq_pkg.sv
design/gfq_chan_if.sv
design/gfq_ctrl.sv
design/gfq_datapath.sv
design/grouped_fifo_queue_unit.sv
dv/tb_grouped_fifo_queue_unit.sv
